FILE: sv/eic_pkg.sv
// Package for the Ethernet/IPv4 frame classifier.
// Holds frame classes, protocol codes, counter slots and shared types.
// No dependencies.
package eic_pkg;

    localparam logic [2:0] CLS_ARP       = 3'd0;
    localparam logic [2:0] CLS_ICMP      = 3'd1;
    localparam logic [2:0] CLS_TCP       = 3'd2;
    localparam logic [2:0] CLS_UDP       = 3'd3;
    localparam logic [2:0] CLS_OTHER_IP  = 3'd4;
    localparam logic [2:0] CLS_OTHER_ETH = 3'd5;

    localparam logic [15:0] ETH_TYPE_ARP  = 16'h0806;
    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam logic [6:0] OFF_TYPE_HI  = 7'd12;
    localparam logic [6:0] OFF_TYPE_LO  = 7'd13;
    localparam logic [6:0] IP_START     = 7'd14;
    localparam logic [6:0] REL_PROTOCOL = 7'd9;
    localparam logic [6:0] TCP_FLAG_REL = 7'd13;
    localparam logic [6:0] OFF_MAX      = 7'd127;
    localparam logic [3:0] MIN_IHL      = 4'd5;
    localparam logic [15:0] SUM_GOOD    = 16'hffff;

    localparam int NUM_CNT     = 8;
    localparam int CNT_ARP     = 0;
    localparam int CNT_IPV4    = 1;
    localparam int CNT_TCP     = 2;
    localparam int CNT_UDP     = 3;
    localparam int CNT_ICMP    = 4;
    localparam int CNT_OTHER   = 5;
    localparam int CNT_GOOD    = 6;
    localparam int CNT_SYNFIN  = 7;

    typedef struct packed {
        logic [2:0] frame_class;
        logic       ip_checksum_ok;
        logic       syn_set;
        logic       fin_set;
    } t_frame_info;

    typedef logic [NUM_CNT-1:0][31:0] t_totals;

endpackage

FILE: sv/eic_if.sv
// Handshake interfaces for the frame classifier's byte and result channels.
// Depends on nothing.
interface eic_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface eic_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  frame_class;
    logic        ip_checksum_ok;
    logic        syn_set;
    logic        fin_set;
    logic [31:0] arp_total;
    logic [31:0] ipv4_total;
    logic [31:0] tcp_total;
    logic [31:0] udp_total;
    logic [31:0] icmp_total;
    logic [31:0] other_total;
    logic [31:0] good_checksum_total;
    logic [31:0] syn_fin_total;

    modport source (
        output valid, output frame_class, output ip_checksum_ok, output syn_set,
        output fin_set, output arp_total, output ipv4_total, output tcp_total,
        output udp_total, output icmp_total, output other_total,
        output good_checksum_total, output syn_fin_total, input ready
    );
    modport sink (
        input valid, input frame_class, input ip_checksum_ok, input syn_set,
        input fin_set, input arp_total, input ipv4_total, input tcp_total,
        input udp_total, input icmp_total, input other_total,
        input good_checksum_total, input syn_fin_total, output ready
    );
endinterface

FILE: sv/eic_frame_parser.sv
// Per-frame header parser: ethertype, IHL, protocol, header checksum, TCP flags.
// Holds the per-frame state and gives the frame's class and flags on the last byte.
// Depends on eic_pkg.
module eic_frame_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    output eic_pkg::t_frame_info o_info
);
    import eic_pkg::*;

    logic [6:0]  r_off;
    logic [15:0] r_et;
    logic [3:0]  r_hw;
    logic [7:0]  r_proto;
    logic [16:0] r_sum;
    logic [7:0]  r_hold;
    logic [1:0]  r_flags;

    logic [6:0]  n_off;
    logic [15:0] n_et;
    logic [3:0]  n_hw;
    logic [7:0]  n_proto;
    logic [16:0] n_sum;
    logic [7:0]  n_hold;
    logic [1:0]  n_flags;

    logic        is_ip;
    logic [6:0]  rel;
    logic [3:0]  eff_words;
    logic [6:0]  hdr_bytes;
    logic [6:0]  flag_pos;
    logic [17:0] raw_sum;

    always_comb begin
        n_et = r_et;
        if (r_off == OFF_TYPE_HI) begin
            n_et = {i_byte, r_et[7:0]};
        end else if (r_off == OFF_TYPE_LO) begin
            n_et = {r_et[15:8], i_byte};
        end

        is_ip = (n_et == ETH_TYPE_IPV4) && (r_off >= IP_START);
        rel   = r_off - IP_START;

        n_hw    = (is_ip && rel == 7'd0) ? i_byte[3:0] : r_hw;
        n_proto = (is_ip && rel == REL_PROTOCOL) ? i_byte : r_proto;

        eff_words = (n_hw < MIN_IHL) ? MIN_IHL : n_hw;
        hdr_bytes = {1'b0, n_hw, 2'b00};
        flag_pos  = {1'b0, eff_words, 2'b00} + TCP_FLAG_REL;

        raw_sum = {1'b0, r_sum} + {2'b00, r_hold, i_byte};
        n_sum   = r_sum;
        n_hold  = r_hold;
        if (is_ip && rel < hdr_bytes) begin
            if (!rel[0]) begin
                n_hold = i_byte;
            end else begin
                n_sum = {1'b0, raw_sum[15:0]} + {15'd0, raw_sum[17:16]};
            end
        end

        n_flags = r_flags;
        if (is_ip && n_proto == PROTO_TCP && rel == flag_pos) begin
            n_flags = i_byte[1:0];
        end

        n_off = (r_off < OFF_MAX) ? r_off + 7'd1 : r_off;
    end

    always_comb begin
        o_info = '0;
        if (n_et == ETH_TYPE_ARP) begin
            o_info.frame_class = CLS_ARP;
        end else if (n_et == ETH_TYPE_IPV4) begin
            o_info.ip_checksum_ok = (n_hw >= MIN_IHL) && (n_off >= IP_START + hdr_bytes)
                                    && (n_sum == {1'b0, SUM_GOOD});
            if (n_proto == PROTO_ICMP) begin
                o_info.frame_class = CLS_ICMP;
            end else if (n_proto == PROTO_TCP) begin
                o_info.frame_class = CLS_TCP;
                o_info.syn_set     = n_flags[1];
                o_info.fin_set     = n_flags[0];
            end else if (n_proto == PROTO_UDP) begin
                o_info.frame_class = CLS_UDP;
            end else begin
                o_info.frame_class = CLS_OTHER_IP;
            end
        end else begin
            o_info.frame_class = CLS_OTHER_ETH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_last)) begin
            r_off   <= '0;
            r_et    <= '0;
            r_hw    <= '0;
            r_proto <= '0;
            r_sum   <= '0;
            r_hold  <= '0;
            r_flags <= '0;
        end else if (i_fire) begin
            r_off   <= n_off;
            r_et    <= n_et;
            r_hw    <= n_hw;
            r_proto <= n_proto;
            r_sum   <= n_sum;
            r_hold  <= n_hold;
            r_flags <= n_flags;
        end
    end

endmodule

FILE: sv/eic_counters.sv
// Saturating event counters, one per class of event, updated once per frame.
// Depends on eic_pkg.
module eic_counters #(
    parameter int COUNTER_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_update,
    input  eic_pkg::t_frame_info i_info,
    output eic_pkg::t_totals     o_totals
);
    import eic_pkg::*;

    localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

    logic [COUNTER_BITS-1:0] r_cnt [NUM_CNT];
    logic [COUNTER_BITS-1:0] n_cnt [NUM_CNT];
    logic [1:0]              amount [NUM_CNT];
    logic                    is_ip;

    always_comb begin
        is_ip = (i_info.frame_class == CLS_ICMP) || (i_info.frame_class == CLS_TCP)
                || (i_info.frame_class == CLS_UDP) || (i_info.frame_class == CLS_OTHER_IP);
        amount[CNT_ARP]    = {1'b0, i_info.frame_class == CLS_ARP};
        amount[CNT_IPV4]   = {1'b0, is_ip};
        amount[CNT_TCP]    = {1'b0, i_info.frame_class == CLS_TCP};
        amount[CNT_UDP]    = {1'b0, i_info.frame_class == CLS_UDP};
        amount[CNT_ICMP]   = {1'b0, i_info.frame_class == CLS_ICMP};
        amount[CNT_OTHER]  = {1'b0, (i_info.frame_class == CLS_OTHER_IP)
                                    || (i_info.frame_class == CLS_OTHER_ETH)};
        amount[CNT_GOOD]   = {1'b0, i_info.ip_checksum_ok};
        amount[CNT_SYNFIN] = {1'b0, i_info.syn_set} + {1'b0, i_info.fin_set};
    end

    for (genvar g = 0; g < NUM_CNT; g++) begin : g_cnt
        always_comb begin
            if (r_cnt[g] > CNT_MAX - COUNTER_BITS'(amount[g])) begin
                n_cnt[g] = CNT_MAX;
            end else begin
                n_cnt[g] = r_cnt[g] + COUNTER_BITS'(amount[g]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cnt[g] <= '0;
            end else if (i_update) begin
                r_cnt[g] <= n_cnt[g];
            end
        end

        assign o_totals[g] = 32'(r_cnt[g]);
    end

endmodule

FILE: sv/ethernet_ipv4_frame_classifier.sv
// Top level of the Ethernet/IPv4 frame classifier.
// Depends on eic_pkg, eic_if, eic_frame_parser and eic_counters.
//
// Usage: frame bytes enter on i_in, destination MAC first, last_byte set on
// the final byte of each frame. One result item per frame leaves on o_out
// with the frame's class, checksum and TCP flag results, and the running
// totals as updated by that frame.
// Each accepted byte goes into an input register; from there the parser and
// counters handle it and, on the last byte, load the result register, whose
// valid flag and fields drive o_out.
// Throughput is one byte per cycle while no last byte is held back by a
// stalled o_out; the parser updates its per-frame state for each byte that
// leaves the input register.
// When o_out stalls, a last byte waits in the input register until the
// result register is free; other bytes keep flowing, and i_in accepts
// while a finished result still waits.
// Reset clears the per-frame state, the totals and both valid flags.
module ethernet_ipv4_frame_classifier #(
    parameter int COUNTER_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    eic_in_if.sink    i_in,
    eic_out_if.source o_out
);
    import eic_pkg::*;

    logic        r_s1_valid;
    logic [7:0]  r_s1_byte;
    logic        r_s1_last;
    logic        r_o_valid;
    t_frame_info r_info;

    logic        out_free;
    logic        s1_fire;
    logic        load_out;
    t_frame_info frame_info;
    t_totals     totals;

    assign out_free   = !r_o_valid || o_out.ready;
    assign s1_fire    = r_s1_valid && (!r_s1_last || out_free);
    assign load_out   = s1_fire && r_s1_last;
    assign i_in.ready = !r_s1_valid || s1_fire;

    eic_frame_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (s1_fire),
        .i_byte  (r_s1_byte),
        .i_last  (r_s1_last),
        .o_info  (frame_info)
    );

    eic_counters #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_counters (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (load_out),
        .i_info   (frame_info),
        .o_totals (totals)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_byte <= i_in.frame_byte;
            r_s1_last <= i_in.last_byte;
        end
        if (load_out) begin
            r_info <= frame_info;
        end
    end

    assign o_out.valid               = r_o_valid;
    assign o_out.frame_class         = r_info.frame_class;
    assign o_out.ip_checksum_ok      = r_info.ip_checksum_ok;
    assign o_out.syn_set             = r_info.syn_set;
    assign o_out.fin_set             = r_info.fin_set;
    assign o_out.arp_total           = totals[CNT_ARP];
    assign o_out.ipv4_total          = totals[CNT_IPV4];
    assign o_out.tcp_total           = totals[CNT_TCP];
    assign o_out.udp_total           = totals[CNT_UDP];
    assign o_out.icmp_total          = totals[CNT_ICMP];
    assign o_out.other_total         = totals[CNT_OTHER];
    assign o_out.good_checksum_total = totals[CNT_GOOD];
    assign o_out.syn_fin_total       = totals[CNT_SYNFIN];

endmodule

FILE: sv/eic_checker.sv
// Port-level checks for the frame classifier, attached by the bind below.
// Depends on eic_pkg and ethernet_ipv4_frame_classifier.
module eic_port_checks (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_frame_class,
    input logic       i_ip_checksum_ok,
    input logic       i_syn_set,
    input logic       i_fin_set
);
    import eic_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("Result item dropped while stalled.");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Result valid after reset.");

    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_frame_class <= CLS_OTHER_ETH)
        else $error("Frame class out of range.");

    a_checksum_ipv4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_ip_checksum_ok |->
            i_frame_class != CLS_ARP && i_frame_class != CLS_OTHER_ETH)
        else $error("Checksum flag on a frame that is not IPv4.");

    a_flags_tcp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_syn_set || i_fin_set) |-> i_frame_class == CLS_TCP)
        else $error("TCP flags on a frame that is not TCP.");

endmodule

bind ethernet_ipv4_frame_classifier eic_port_checks u_eic_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_frame_class    (o_out.frame_class),
    .i_ip_checksum_ok (o_out.ip_checksum_ok),
    .i_syn_set        (o_out.syn_set),
    .i_fin_set        (o_out.fin_set)
);

FILE: test/eic_checker.sv
`timescale 1ns / 1ps
// Checker for the frame classifier: watches the byte and result channels,
// predicts each frame's result item and compares it field by field.
// Depends on eic_pkg and eic_if.
module eic_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    eic_in_if    i_bytes,
    eic_out_if   i_results,
    output int   o_fail_count,
    output int   o_pending
);
    import eic_pkg::*;

    localparam longint unsigned TALLY_MAX = 64'h0000_0000_ffff_ffff;

    typedef struct packed {
        t_frame_info info;
        t_totals     totals;
    } t_frame_result;

    logic [6:0]      offset;
    logic [15:0]     eth_type;
    logic [3:0]      ihl_words;
    logic [7:0]      proto;
    logic [16:0]     csum_acc;
    logic [7:0]      csum_hi;
    logic [1:0]      tcp_flags;
    longint unsigned tally [NUM_CNT];

    t_frame_result frame_results_q[$];
    int            fails = 0;
    int            result_idx = 0;
    string         tally_name [NUM_CNT] = '{"arp_total", "ipv4_total", "tcp_total",
        "udp_total", "icmp_total", "other_total", "good_checksum_total", "syn_fin_total"};

    task automatic report(input string msg);
        $display("ERROR: result %0d: %s", result_idx, msg);
        fails++;
    endtask

    task automatic clear_frame();
        offset    = '0;
        eth_type  = '0;
        ihl_words = '0;
        proto     = '0;
        csum_acc  = '0;
        csum_hi   = '0;
        tcp_flags = '0;
    endtask

    task automatic bump(input int slot, input int amount);
        if (tally[slot] > TALLY_MAX || longint'(amount) > TALLY_MAX - tally[slot]) begin
            tally[slot] = TALLY_MAX;
        end else begin
            tally[slot] = tally[slot] + amount;
        end
    endtask

    task automatic classify_byte(input logic [7:0] b, input logic last);
        int            rel;
        int            hlen;
        int            s;
        logic          ok;
        t_frame_result want;
        if (offset == OFF_TYPE_HI) begin
            eth_type[15:8] = b;
        end else if (offset == OFF_TYPE_LO) begin
            eth_type[7:0] = b;
        end
        if (eth_type == ETH_TYPE_IPV4 && offset >= IP_START) begin
            rel = int'(offset) - int'(IP_START);
            if (rel == 0) begin
                ihl_words = b[3:0];
            end
            if (rel == int'(REL_PROTOCOL)) begin
                proto = b;
            end
            hlen = 4 * ((ihl_words < MIN_IHL) ? int'(MIN_IHL) : int'(ihl_words));
            if (rel < 4 * int'(ihl_words)) begin
                if (rel % 2 == 0) begin
                    csum_hi = b;
                end else begin
                    s = int'(csum_acc) + int'({csum_hi, b});
                    csum_acc = 17'((s & 'hffff) + (s >> 16));
                end
            end
            if (proto == PROTO_TCP && rel == hlen + int'(TCP_FLAG_REL)) begin
                tcp_flags = b[1:0];
            end
        end
        if (offset < OFF_MAX) begin
            offset++;
        end
        if (last) begin
            want = '0;
            if (eth_type == ETH_TYPE_ARP) begin
                want.info.frame_class = CLS_ARP;
                bump(CNT_ARP, 1);
            end else if (eth_type == ETH_TYPE_IPV4) begin
                ok = (ihl_words >= MIN_IHL)
                    && (int'(offset) >= int'(IP_START) + 4 * int'(ihl_words))
                    && (csum_acc == {1'b0, SUM_GOOD});
                want.info.ip_checksum_ok = ok;
                if (proto == PROTO_ICMP) begin
                    want.info.frame_class = CLS_ICMP;
                    bump(CNT_ICMP, 1);
                end else if (proto == PROTO_TCP) begin
                    want.info.frame_class = CLS_TCP;
                    want.info.syn_set = tcp_flags[1];
                    want.info.fin_set = tcp_flags[0];
                    bump(CNT_TCP, 1);
                    bump(CNT_SYNFIN, int'(tcp_flags[1]) + int'(tcp_flags[0]));
                end else if (proto == PROTO_UDP) begin
                    want.info.frame_class = CLS_UDP;
                    bump(CNT_UDP, 1);
                end else begin
                    want.info.frame_class = CLS_OTHER_IP;
                    bump(CNT_OTHER, 1);
                end
                bump(CNT_IPV4, 1);
                if (ok) begin
                    bump(CNT_GOOD, 1);
                end
            end else begin
                want.info.frame_class = CLS_OTHER_ETH;
                bump(CNT_OTHER, 1);
            end
            for (int i = 0; i < NUM_CNT; i++) begin
                want.totals[i] = tally[i][31:0];
            end
            frame_results_q = {frame_results_q, want};
            clear_frame();
        end
    endtask

    task automatic check_result();
        t_frame_result want;
        logic [31:0]   got [NUM_CNT];
        got[CNT_ARP]    = i_results.arp_total;
        got[CNT_IPV4]   = i_results.ipv4_total;
        got[CNT_TCP]    = i_results.tcp_total;
        got[CNT_UDP]    = i_results.udp_total;
        got[CNT_ICMP]   = i_results.icmp_total;
        got[CNT_OTHER]  = i_results.other_total;
        got[CNT_GOOD]   = i_results.good_checksum_total;
        got[CNT_SYNFIN] = i_results.syn_fin_total;
        if (frame_results_q.size() == 0) begin
            report("result item arrived with no frame outstanding");
        end else begin
            want = frame_results_q.pop_front();
            if (i_results.frame_class !== want.info.frame_class) begin
                report($sformatf("frame_class expected %0d got %0d",
                    want.info.frame_class, i_results.frame_class));
            end
            if (i_results.ip_checksum_ok !== want.info.ip_checksum_ok) begin
                report($sformatf("ip_checksum_ok expected %0b got %0b",
                    want.info.ip_checksum_ok, i_results.ip_checksum_ok));
            end
            if (i_results.syn_set !== want.info.syn_set) begin
                report($sformatf("syn_set expected %0b got %0b",
                    want.info.syn_set, i_results.syn_set));
            end
            if (i_results.fin_set !== want.info.fin_set) begin
                report($sformatf("fin_set expected %0b got %0b",
                    want.info.fin_set, i_results.fin_set));
            end
            for (int i = 0; i < NUM_CNT; i++) begin
                if (got[i] !== want.totals[i]) begin
                    report($sformatf("%s expected %0d got %0d",
                        tally_name[i], want.totals[i], got[i]));
                end
            end
        end
        result_idx++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_frame();
            for (int i = 0; i < NUM_CNT; i++) begin
                tally[i] = 0;
            end
            frame_results_q.delete();
        end else begin
            if (i_results.valid && i_results.ready) begin
                check_result();
            end
            if (i_bytes.valid && i_bytes.ready) begin
                classify_byte(i_bytes.frame_byte, i_bytes.last_byte);
            end
        end
        o_pending    <= frame_results_q.size();
        o_fail_count <= fails;
    end

endmodule

FILE: test/ethernet_ipv4_frame_classifier_tb.sv
`timescale 1ns / 1ps
// Testbench top for the frame classifier: builds directed and random frames,
// drives them with random gaps and stalls, and gives the verdict.
// Depends on eic_pkg, eic_if, eic_checker and the classifier itself.
module ethernet_ipv4_frame_classifier_tb;
    import eic_pkg::*;

    localparam int QUIET_LIMIT  = 1000;
    localparam int RANDOM_BYTES = 900;
    localparam int CSUM_REL     = 10;
    localparam int TCP_HDR_LEN  = 20;
    localparam int MIN_HDR_LEN  = 20;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending_results;
    int   quiet_cycles = 0;
    int   sent_bytes = 0;
    int   gap_pct = 28;
    int   stall_pct = 28;

    logic [7:0] frame_buf[$];

    eic_in_if  byte_ch ();
    eic_out_if result_ch ();

    ethernet_ipv4_frame_classifier dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (result_ch)
    );

    eic_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_bytes      (byte_ch),
        .i_results    (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (byte_ch.valid && byte_ch.ready)
                || (result_ch.valid && result_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < gap_pct) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid      <= 1'b1;
        byte_ch.frame_byte <= b;
        byte_ch.last_byte  <= last;
        do @(posedge i_clk); while (!byte_ch.ready);
        sent_bytes++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_buf.size(); i++) begin
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
        end
    endtask

    task automatic append_byte(input logic [7:0] b);
        frame_buf = {frame_buf, b};
    endtask

    task automatic fill_random(input int count);
        for (int i = 0; i < count; i++) begin
            append_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic build_eth(input logic [15:0] eth_type, input int body_len);
        frame_buf.delete();
        fill_random(12);
        append_byte(eth_type[15:8]);
        append_byte(eth_type[7:0]);
        fill_random(body_len);
    endtask

    task automatic build_ipv4(input logic [3:0] ver, input logic [3:0] ihl,
                              input logic [7:0] proto, input logic [7:0] flags,
                              input bit corrupt, input int tail_len);
        int hdr_len;
        int sum;
        int pos;
        hdr_len = (ihl < MIN_IHL) ? MIN_HDR_LEN : 4 * int'(ihl);
        build_eth(ETH_TYPE_IPV4, hdr_len);
        frame_buf[IP_START] = {ver, ihl};
        frame_buf[IP_START + REL_PROTOCOL] = proto;
        frame_buf[IP_START + CSUM_REL] = 8'h00;
        frame_buf[IP_START + CSUM_REL + 1] = 8'h00;
        if (ihl >= MIN_IHL) begin
            sum = 0;
            for (int i = 0; i < hdr_len; i += 2) begin
                sum += int'({frame_buf[IP_START + i], frame_buf[IP_START + i + 1]});
            end
            while (sum > 'hffff) begin
                sum = (sum & 'hffff) + (sum >> 16);
            end
            frame_buf[IP_START + CSUM_REL] = ~sum[15:8];
            frame_buf[IP_START + CSUM_REL + 1] = ~sum[7:0];
            if (corrupt) begin
                pos = $urandom_range(CSUM_REL, hdr_len - 1);
                frame_buf[IP_START + pos] ^= 8'(1 << $urandom_range(0, 7));
            end
        end
        if (proto == PROTO_TCP) begin
            fill_random(TCP_HDR_LEN);
            frame_buf[IP_START + hdr_len + TCP_FLAG_REL] = flags;
        end
        fill_random(tail_len);
    endtask

    task automatic trim_frame(input int len);
        while (frame_buf.size() > len && frame_buf.size() > 1) begin
            void'(frame_buf.pop_back());
        end
    endtask

    task automatic run_directed();
        frame_buf = '{8'hff};
        send_frame();
        build_eth(16'h0000, 0);
        trim_frame(13);
        frame_buf[OFF_TYPE_HI] = 8'h08;
        send_frame();
        build_eth(16'h0000, 0);
        trim_frame(12);
        send_frame();
        build_eth(ETH_TYPE_ARP, 28);
        for (int i = 0; i < 12; i++) frame_buf[i] = 8'h00;
        send_frame();
        build_eth(ETH_TYPE_ARP, 0);
        for (int i = 0; i < 12; i++) frame_buf[i] = 8'hff;
        send_frame();
        build_eth(16'hffff, 46);
        send_frame();
        build_ipv4(4'd4, MIN_IHL, PROTO_ICMP, 8'h00, 1'b0, 10);
        send_frame();
        build_ipv4(4'd4, MIN_IHL, PROTO_UDP, 8'h00, 1'b1, 8);
        send_frame();
        build_ipv4(4'd4, MIN_IHL, PROTO_TCP, 8'hff, 1'b0, 0);
        send_frame();
        build_ipv4(4'd4, 4'd15, PROTO_TCP, 8'h00, 1'b0, 4);
        send_frame();
        build_ipv4(4'd4, 4'd15, PROTO_TCP, 8'h03, 1'b0, 0);
        send_frame();
        build_ipv4(4'd4, MIN_IHL, PROTO_TCP, 8'hff, 1'b0, 0);
        trim_frame(int'(IP_START) + MIN_HDR_LEN + 10);
        send_frame();
        build_ipv4(4'd4, MIN_IHL, PROTO_TCP, 8'h00, 1'b0, 0);
        trim_frame(int'(IP_START) + 5);
        send_frame();
        build_ipv4(4'd4, 4'd8, PROTO_UDP, 8'h00, 1'b0, 0);
        trim_frame(int'(IP_START) + MIN_HDR_LEN);
        send_frame();
        build_ipv4(4'd4, 4'd0, PROTO_TCP, 8'h02, 1'b0, 2);
        send_frame();
        build_ipv4(4'd4, 4'd4, PROTO_UDP, 8'h00, 1'b0, 3);
        send_frame();
        build_ipv4(4'd4, 4'd6, 8'hff, 8'h00, 1'b0, 5);
        send_frame();
        build_ipv4(4'd4, MIN_IHL, 8'h00, 8'h00, 1'b0, 5);
        send_frame();
        build_ipv4(4'hf, MIN_IHL, PROTO_TCP, 8'h01, 1'b0, 2);
        send_frame();
        build_ipv4(4'd4, MIN_IHL, PROTO_TCP, 8'hfe, 1'b0, 160);
        send_frame();
    endtask

    task automatic build_random_frame();
        int         kind;
        logic [3:0] ihl;
        logic [7:0] proto;
        kind = $urandom_range(0, 99);
        if (kind < 60 || kind >= 90) begin
            ihl = ($urandom_range(0, 9) < 7) ? MIN_IHL : 4'($urandom_range(5, 15));
            case ($urandom_range(0, 4))
                0:       proto = PROTO_ICMP;
                1, 2:    proto = PROTO_TCP;
                3:       proto = PROTO_UDP;
                default: proto = 8'($urandom_range(0, 255));
            endcase
            build_ipv4(($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'd4, ihl,
                proto, 8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0,
                ($urandom_range(0, 29) == 0) ? 100 : $urandom_range(0, 18));
            if (kind >= 90) begin
                for (int i = IP_START; i < frame_buf.size(); i++) begin
                    frame_buf[i] = 8'($urandom_range(0, 255));
                end
            end
            if ($urandom_range(0, 9) == 0) begin
                trim_frame($urandom_range(1, frame_buf.size()));
            end
        end else if (kind < 70) begin
            build_eth(ETH_TYPE_ARP, 28);
            if ($urandom_range(0, 4) == 0) begin
                trim_frame($urandom_range(1, frame_buf.size()));
            end
        end else if (kind < 80) begin
            build_eth(16'($urandom_range(0, 65535)), $urandom_range(0, 50));
        end else begin
            frame_buf.delete();
            fill_random($urandom_range(1, 20));
        end
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        byte_ch.valid      <= 1'b0;
        byte_ch.frame_byte <= 8'h00;
        byte_ch.last_byte  <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        sent_bytes = 0;
        while (sent_bytes < RANDOM_BYTES) begin
            if (sent_bytes >= 300 && sent_bytes < 600) begin
                gap_pct   <= 0;
                stall_pct <= 0;
            end else begin
                gap_pct   <= 28;
                stall_pct <= 28;
            end
            build_random_frame();
            send_frame();
        end
        byte_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/eic_pkg.sv
sv/eic_if.sv
sv/eic_frame_parser.sv
sv/eic_counters.sv
sv/ethernet_ipv4_frame_classifier.sv
sv/eic_checker.sv
test/eic_checker.sv
test/ethernet_ipv4_frame_classifier_tb.sv
